### rtl/infix_to_prefix_converter_top_defines.svh
// Assertion macros shared by the converter RTL.
`ifndef INFIX_TO_PREFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_PREFIX_CONVERTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_IMM(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/itp_pkg.sv
// Package: sizes, character codes, types and helpers of the infix-to-prefix converter.
package itp_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_CHAR = 2'd1,
    ERR_PAREN    = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_BAD
  } cls_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN,
    ST_CLOSE_RD,
    ST_CLOSE,
    ST_OP_RD,
    ST_OP,
    ST_FIN_RD,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT,
    ST_ERR
  } state_e;

  typedef enum logic {
    SRC_SCAN,
    SRC_STACK
  } emit_src_e;

  typedef enum logic {
    PSH_SCAN,
    PSH_CUR
  } push_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      expr_wr;
    logic      scan_init;
    logic      scan_rd;
    logic      cur_ld;
    logic      stk_push;
    push_src_e push_src;
    logic      stk_rd;
    logic      stk_dec;
    logic      out_wr;
    emit_src_e out_src;
    logic      emit_init;
    logic      emit_rd;
    logic      res_ld;
    logic      res_err;
    logic      err_ld;
    err_e      err_code;
    logic      clr_run;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ovf_any;
    logic scan_done;
    cls_e cls;
    logic sp_zero;
    logic top_open;
    logic top_pops;
    logic out_empty;
    logic emit_done;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] swap_paren(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c == CH_OPEN) begin
      r = CH_CLOSE;
    end else if (c == CH_CLOSE) begin
      r = CH_OPEN;
    end
    return r;
  endfunction

  function automatic logic [1:0] rank_of(input logic [7:0] c);
    logic [1:0] r;
    r = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) begin
      r = 2'd1;
    end else if (c == CH_MUL || c == CH_DIV) begin
      r = 2'd2;
    end else if (c == CH_POW) begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    r = CLS_BAD;
    if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
        (c >= 8'h30 && c <= 8'h39)) begin
      r = CLS_OPERAND;
    end else if (c == CH_OPEN) begin
      r = CLS_OPEN;
    end else if (c == CH_CLOSE) begin
      r = CLS_CLOSE;
    end else if (rank_of(c) != 2'd0) begin
      r = CLS_OPER;
    end
    return r;
  endfunction

endpackage

### rtl/itp_in_if.sv
// Input channel: one infix character word per handshake.
interface itp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

### rtl/itp_out_if.sv
// Output channel: one prefix character word per handshake.
interface itp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;
  logic [1:0] error_code;

  modport source (output valid, output out_char, output out_last, output error_code,
                  input ready);
  modport sink   (input valid, input out_char, input out_last, input error_code,
                  output ready);
endinterface

### rtl/infix_to_prefix_converter_top.sv
// Top level: infix-to-prefix converter, controller plus datapath.
//
//   channel   dir  word                             accepted when
//   in_i      in   in_char[7:0], in_last            valid && ready
//   out_o     out  out_char[7:0], out_last, code    valid && ready
//
// One character is taken per cycle while loading. After the final one the scan
// reads the stored text backwards; operators check the stack top, a ')' pops it,
// the finish pops the rest, and then each prefix word is read and sent; the
// memory reads are registered. Reset is asynchronous, active low, and empties
// all stores. Input is taken only while loading; a stalled output holds its word
// and pauses the emit; loading resumes once the final word is registered.
module infix_to_prefix_converter_top
  import itp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  itp_in_if.sink           in_i,
  itp_out_if.source        out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  itp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.in_last),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  itp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_char_i    (in_i.in_char),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_char_o   (out_o.out_char),
    .out_last_o   (out_o.out_last),
    .error_code_o (out_o.error_code)
  );

endmodule

### rtl/itp_dp.sv
// Datapath: expression, operator stack and output memories, counters, result register.
`include "infix_to_prefix_converter_top_defines.svh"

module itp_dp
  import itp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  output sts_t       sts_o,
  input  logic [7:0] in_char_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic       out_last_o,
  output logic [1:0] error_code_o
);

  logic [7:0] expr_mem [DEPTH];
  logic [7:0] stk_mem  [DEPTH];
  logic [7:0] out_mem  [DEPTH];

  logic [CW-1:0] expr_len_q, idx_q, sp_q, out_len_q, emit_q;
  logic          ovf_q;
  logic [7:0]    expr_rd_q, stk_rd_q, out_rd_q, cur_q;
  err_e          err_q;
  logic          out_valid_q, out_last_q;
  logic [7:0]    out_char_q;
  logic [1:0]    out_code_q;

  logic [CW-1:0] idx_m1, sp_m1, emit_m1;
  logic          expr_full, stk_full, out_full;
  logic [7:0]    scan_c, push_val, emit_val;
  logic [1:0]    rank_top, rank_cur;

  assign idx_m1    = idx_q - 1'b1;
  assign sp_m1     = sp_q - 1'b1;
  assign emit_m1   = emit_q - 1'b1;
  assign expr_full = (expr_len_q == CW'(DEPTH));
  assign stk_full  = (sp_q == CW'(DEPTH));
  assign out_full  = (out_len_q == CW'(DEPTH));

  // Scan runs over the stored text backwards with parentheses swapped.
  assign scan_c   = swap_paren(expr_rd_q);
  assign push_val = (cmd_i.push_src == PSH_CUR) ? cur_q : scan_c;
  assign emit_val = (cmd_i.out_src == SRC_STACK) ? stk_rd_q : scan_c;
  assign rank_top = rank_of(stk_rd_q);
  assign rank_cur = rank_of(cur_q);

  always_comb begin
    sts_o.ovf_any   = ovf_q || expr_full;
    sts_o.scan_done = (idx_q == '0);
    sts_o.cls       = classify(scan_c);
    sts_o.sp_zero   = (sp_q == '0);
    sts_o.top_open  = (stk_rd_q == CH_OPEN);
    sts_o.top_pops  = (rank_top > rank_cur) || (rank_top == rank_cur && cur_q == CH_POW);
    sts_o.out_empty = (out_len_q == '0);
    sts_o.emit_done = (emit_q == '0);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Memories: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.expr_wr && !expr_full) begin
      expr_mem[expr_len_q[AW-1:0]] <= in_char_i;
    end
    if (cmd_i.scan_rd) begin
      expr_rd_q <= expr_mem[idx_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stk_push && !stk_full) begin
      stk_mem[sp_q[AW-1:0]] <= push_val;
    end
    if (cmd_i.stk_rd) begin
      stk_rd_q <= stk_mem[sp_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_wr && !out_full) begin
      out_mem[out_len_q[AW-1:0]] <= emit_val;
    end
    if (cmd_i.emit_rd) begin
      out_rd_q <= out_mem[emit_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cur_ld) begin
      cur_q <= scan_c;
    end
    if (cmd_i.err_ld) begin
      err_q <= cmd_i.err_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expr_len_q <= '0;
      ovf_q      <= 1'b0;
      sp_q       <= '0;
      out_len_q  <= '0;
    end else if (cmd_i.clr_run) begin
      expr_len_q <= '0;
      ovf_q      <= 1'b0;
      sp_q       <= '0;
      out_len_q  <= '0;
    end else begin
      if (cmd_i.expr_wr) begin
        if (expr_full) begin
          ovf_q <= 1'b1;
        end else begin
          expr_len_q <= expr_len_q + 1'b1;
        end
      end
      if (cmd_i.stk_push && !stk_full) begin
        sp_q <= sp_q + 1'b1;
      end else if (cmd_i.stk_dec) begin
        sp_q <= sp_m1;
      end
      if (cmd_i.out_wr && !out_full) begin
        out_len_q <= out_len_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      emit_q <= '0;
    end else begin
      if (cmd_i.scan_init) begin
        idx_q <= expr_len_q + 1'b1;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_m1;
      end
      if (cmd_i.emit_init) begin
        emit_q <= out_len_q;
      end else if (cmd_i.emit_rd) begin
        emit_q <= emit_m1;
      end
    end
  end

  // Result register: hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      if (cmd_i.res_err) begin
        out_char_q <= 8'h00;
        out_last_q <= 1'b1;
        out_code_q <= err_q;
      end else begin
        out_char_q <= out_rd_q;
        out_last_q <= (emit_q == '0);
        out_code_q <= ERR_NONE;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_last_o   = out_last_q;
  assign error_code_o = out_code_q;

  `ITP_ASSERT_IMM(a_res_free, clk_i, rst_ni, cmd_i.res_ld, !out_valid_q || out_ready_i, "result word overwrites a pending word")
  `ITP_ASSERT_IMM(a_pop_nonempty, clk_i, rst_ni, cmd_i.stk_dec, sp_q != '0, "pop from empty operator stack")
  `ITP_ASSERT_IMM(a_scan_bound, clk_i, rst_ni, cmd_i.scan_rd, idx_q != '0, "scan read past start of expression")
  `ITP_ASSERT_NXT(a_run_clear, clk_i, rst_ni, cmd_i.res_ld && cmd_i.clr_run, expr_len_q == '0 && sp_q == '0 && out_len_q == '0, "run state not cleared after final word")

endmodule

### rtl/itp_ctrl.sv
// Controller: state machine that sequences load, reversed scan, stack moves and emit.
module itp_ctrl
  import itp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_last_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   in_acc;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && in_last_i) begin
          state_d = sts_i.ovf_any ? ST_ERR : ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: state_d = sts_i.scan_done ? ST_FIN_RD : ST_SCAN;
      ST_SCAN: begin
        unique case (sts_i.cls)
          CLS_OPERAND, CLS_OPEN: state_d = ST_SCAN_RD;
          CLS_CLOSE:             state_d = ST_CLOSE_RD;
          CLS_OPER:              state_d = ST_OP_RD;
          default:               state_d = ST_ERR;
        endcase
      end
      ST_CLOSE_RD: state_d = sts_i.sp_zero ? ST_ERR : ST_CLOSE;
      ST_CLOSE:    state_d = sts_i.top_open ? ST_SCAN_RD : ST_CLOSE_RD;
      ST_OP_RD:    state_d = sts_i.sp_zero ? ST_SCAN_RD : ST_OP;
      ST_OP:       state_d = sts_i.top_pops ? ST_OP_RD : ST_SCAN_RD;
      ST_FIN_RD: begin
        if (sts_i.sp_zero) begin
          state_d = sts_i.out_empty ? ST_ERR : ST_EMIT_RD;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN:     state_d = sts_i.top_open ? ST_ERR : ST_FIN_RD;
      ST_EMIT_RD: state_d = sts_i.out_free ? ST_EMIT : ST_EMIT_RD;
      ST_EMIT:    state_d = sts_i.emit_done ? ST_LOAD : ST_EMIT_RD;
      ST_ERR:     state_d = sts_i.out_free ? ST_LOAD : ST_ERR;
      default:    state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.push_src = PSH_SCAN;
    cmd_o.out_src  = SRC_SCAN;
    cmd_o.err_code = ERR_NONE;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.expr_wr = in_acc;
        if (in_acc && in_last_i) begin
          if (sts_i.ovf_any) begin
            cmd_o.err_ld   = 1'b1;
            cmd_o.err_code = ERR_OVERFLOW;
          end else begin
            cmd_o.scan_init = 1'b1;
          end
        end
      end
      ST_SCAN_RD: cmd_o.scan_rd = !sts_i.scan_done;
      ST_SCAN: begin
        cmd_o.cur_ld = 1'b1;
        unique case (sts_i.cls)
          CLS_OPERAND: cmd_o.out_wr = 1'b1;
          CLS_OPEN:    cmd_o.stk_push = 1'b1;
          CLS_CLOSE, CLS_OPER: ;
          default: begin
            cmd_o.err_ld   = 1'b1;
            cmd_o.err_code = ERR_BAD_CHAR;
          end
        endcase
      end
      ST_CLOSE_RD: begin
        if (sts_i.sp_zero) begin
          cmd_o.err_ld   = 1'b1;
          cmd_o.err_code = ERR_PAREN;
        end else begin
          cmd_o.stk_rd  = 1'b1;
          cmd_o.stk_dec = 1'b1;
        end
      end
      ST_CLOSE: begin
        cmd_o.out_src = SRC_STACK;
        cmd_o.out_wr  = !sts_i.top_open;
      end
      ST_OP_RD: begin
        cmd_o.push_src = PSH_CUR;
        cmd_o.stk_push = sts_i.sp_zero;
        cmd_o.stk_rd   = !sts_i.sp_zero;
      end
      ST_OP: begin
        cmd_o.push_src = PSH_CUR;
        cmd_o.out_src  = SRC_STACK;
        if (sts_i.top_pops) begin
          cmd_o.out_wr  = 1'b1;
          cmd_o.stk_dec = 1'b1;
        end else begin
          cmd_o.stk_push = 1'b1;
        end
      end
      ST_FIN_RD: begin
        if (sts_i.sp_zero) begin
          if (sts_i.out_empty) begin
            cmd_o.err_ld   = 1'b1;
            cmd_o.err_code = ERR_NONE;
          end else begin
            cmd_o.emit_init = 1'b1;
          end
        end else begin
          cmd_o.stk_rd  = 1'b1;
          cmd_o.stk_dec = 1'b1;
        end
      end
      ST_FIN: begin
        cmd_o.out_src = SRC_STACK;
        if (sts_i.top_open) begin
          cmd_o.err_ld   = 1'b1;
          cmd_o.err_code = ERR_PAREN;
        end else begin
          cmd_o.out_wr = 1'b1;
        end
      end
      ST_EMIT_RD: cmd_o.emit_rd = sts_i.out_free;
      ST_EMIT: begin
        cmd_o.res_ld  = 1'b1;
        cmd_o.clr_run = sts_i.emit_done;
      end
      ST_ERR: begin
        cmd_o.res_ld  = sts_i.out_free;
        cmd_o.res_err = 1'b1;
        cmd_o.clr_run = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule
